// ===== design/sbda_pkg.sv =====
package sbda_pkg;

    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 6;

    localparam logic [CHAR_BITS-1:0] DIGIT_ZERO = 6'd48;
    localparam logic [CHAR_BITS-1:0] MINUS_SIGN = 6'd45;

    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } t_cell_ctl;

endpackage

// ===== design/sbda_bcd_cell.sv =====
module sbda_bcd_cell (
    input  logic                           i_clk,
    input  sbda_pkg::t_cell_ctl            i_ctl,
    input  logic                           i_bit,
    input  logic [sbda_pkg::DIGIT_BITS-1:0] i_digit,
    output logic                           o_bit,
    output logic [sbda_pkg::DIGIT_BITS-1:0] o_digit
);
    import sbda_pkg::*;

    logic [DIGIT_BITS-1:0] r_digit;
    logic [DIGIT_BITS-1:0] n_digit;
    logic [DIGIT_BITS-1:0] adj;

    // A digit of five or more doubles past nine, so it is corrected by three first.
    assign adj   = (r_digit >= DIGIT_BITS'(5)) ? r_digit + DIGIT_BITS'(3) : r_digit;
    assign o_bit = adj[DIGIT_BITS-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift_bit) begin
            n_digit = {adj[DIGIT_BITS-2:0], i_bit};
        end else if (i_ctl.shift_digit) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== design/sbda_digit_chain.sv =====
module sbda_digit_chain #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                            i_clk,
    input  sbda_pkg::t_cell_ctl             i_ctl,
    input  logic                            i_bit,
    output logic [sbda_pkg::DIGIT_BITS-1:0] o_top_digit
);
    import sbda_pkg::*;

    logic                  bit_link   [NUM_DIGITS+1];
    logic [DIGIT_BITS-1:0] digit_link [NUM_DIGITS+1];

    assign bit_link[0]   = i_bit;
    assign digit_link[0] = '0;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sbda_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (bit_link[g]),
            .i_digit (digit_link[g]),
            .o_bit   (bit_link[g+1]),
            .o_digit (digit_link[g+1])
        );
    end

    assign o_top_digit = digit_link[NUM_DIGITS];

endmodule

// ===== design/signed_binary_to_decimal_ascii.sv =====
// Channel  Direction  Ports                              Handshake
// input    in         i_value                            i_valid / o_stall
// output   out        o_char_code, o_last                o_valid / i_stall
//
// A word is loaded, then shifted and corrected bit by bit through the row of BCD
// cells. A negative word then sends a minus sign. Leading zeros are dropped, keeping
// at least one digit, and the remaining digits are sent, the last one marked by o_last.
// Reset is synchronous and active low; it returns the controller to idle.
// A stall on the output holds the current character and pauses the character stream.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [VALUE_BITS-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sbda_pkg::CHAR_BITS-1:0] o_char_code,
    output logic                           o_last
);
    import sbda_pkg::*;

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [REM_BITS-1:0]   r_rem, n_rem;
    logic                  r_o_valid, n_o_valid;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;

    t_cell_ctl             ctl;
    logic [DIGIT_BITS-1:0] top_digit;
    logic                  out_free;
    logic                  accept;
    logic [VALUE_BITS-1:0] raw;

    sbda_digit_chain #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_bit       (r_mag[VALUE_BITS-1]),
        .o_top_digit (top_digit)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign raw         = VALUE_BITS'(i_value);
    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_o_valid = out_free ? 1'b0 : r_o_valid;
        n_char    = r_char;
        n_last    = r_last;
        ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_neg   = raw[VALUE_BITS-1];
                    n_mag   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
                    n_cnt   = CNT_BITS'(VALUE_BITS);
                    n_rem   = REM_BITS'(NUM_DIGITS);
                    ctl.clear = 1'b1;
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                ctl.shift_bit = 1'b1;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    n_state = r_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = MINUS_SIGN;
                    n_last    = 1'b0;
                    n_state   = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == '0 && r_rem != REM_BITS'(1)) begin
                    ctl.shift_digit = 1'b1;
                    n_rem = r_rem - REM_BITS'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = DIGIT_ZERO + CHAR_BITS'(top_digit);
                    n_last    = (r_rem == REM_BITS'(1));
                    ctl.shift_digit = 1'b1;
                    n_rem     = r_rem - REM_BITS'(1);
                    if (r_rem == REM_BITS'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule
